// ----- rtl/core/dat_pkg.sv -----
// Package for the drive alignment torque block: widths, CORDIC constants,
// register indexes and shared types. No dependencies.
package dat_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int PIPE_DEPTH    = 2 * CORDIC_STAGES + 8;
   localparam int LAST_STAGE    = PIPE_DEPTH - 1;
   localparam int M1_STAGE      = 2 * CORDIC_STAGES + 5;

   localparam int FW  = 16;   // input and register field width
   localparam int RW  = 32;   // rotation x/y width
   localparam int ZW  = 32;   // angle accumulator width
   localparam int VW  = 48;   // vectoring x/y width
   localparam int AW  = 17;   // rounded angle width
   localparam int LW  = 20;   // force length width
   localparam int SQW = 40;   // squared force length width
   localparam int OW  = 32;   // result width
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_ROT = 2'd2;

   localparam logic signed [ZW-1:0] ANG_PI      = 32'sd843314857;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 32'sd421657429;
   localparam logic signed [RW-1:0] ONE_Q28     = 32'sd268435456;

   typedef struct packed {
      logic [FW-1:0] weight_ang;
      logic [FW-1:0] weight_lin;
      logic          last;
   } tag_type;

   typedef struct packed {
      logic signed [FW-1:0] px;
      logic signed [FW-1:0] py;
      logic                 neg;
   } pos_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = 32'sd210828714;
         1:  v = 32'sd124459457;
         2:  v = 32'sd65760959;
         3:  v = 32'sd33381290;
         4:  v = 32'sd16755422;
         5:  v = 32'sd8385879;
         6:  v = 32'sd4193963;
         7:  v = 32'sd2097109;
         8:  v = 32'sd1048571;
         9:  v = 32'sd524287;
         10: v = 32'sd262144;
         11: v = 32'sd131072;
         12: v = 32'sd65536;
         13: v = 32'sd32768;
         14: v = 32'sd16384;
         15: v = 32'sd8192;
         16: v = 32'sd4096;
         17: v = 32'sd2048;
         18: v = 32'sd1024;
         19: v = 32'sd512;
         20: v = 32'sd256;
         21: v = 32'sd128;
         22: v = 32'sd64;
         23: v = 32'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/dat_if.sv -----
// Valid/ready channel interfaces for the drive alignment torque block.
// Depends on dat_pkg.
interface dat_req_if;
   import dat_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [FW-1:0] pivot_angle;
   logic signed [FW-1:0] pos_x;
   logic signed [FW-1:0] pos_y;
   logic [FW-1:0]        weight_ang;
   logic [FW-1:0]        weight_lin;
   logic                 last_drive;
   modport source (output valid, pivot_angle, pos_x, pos_y, weight_ang, weight_lin,
                   last_drive, input ready);
   modport sink (input valid, pivot_angle, pos_x, pos_y, weight_ang, weight_lin,
                 last_drive, output ready);
endinterface

interface dat_rsp_if;
   import dat_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [OW-1:0] align_torque;
   logic                 last_result;
   modport source (output valid, align_torque, last_result, input ready);
   modport sink (input valid, align_torque, last_result, output ready);
endinterface

interface dat_csr_if;
   import dat_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [FW-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/dat_vec_cordic.sv -----
// Pipelined vectoring CORDIC: atan2(y, x) rounded to signed Q3.13, through an input
// register, the CORDIC stages and an output register. Depends on dat_pkg.
module dat_vec_cordic import dat_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [VW-1:0] y_in,
   input  logic signed [VW-1:0] x_in,
   output logic signed [AW-1:0] angle
);

   logic signed [VW-1:0] vx_ff [0:CORDIC_STAGES];
   logic signed [VW-1:0] vy_ff [0:CORDIC_STAGES];
   logic signed [ZW-1:0] vz_ff [0:CORDIC_STAGES];
   logic                 zero_ff [0:CORDIC_STAGES];
   logic signed [AW-1:0] angle_ff;
   logic signed [VW-1:0] x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;
   logic signed [ZW-1:0] zr;

   always_comb begin
      x0_in = x_in;
      y0_in = y_in;
      z0_in = '0;
      if (x_in[VW-1]) begin
         if (!y_in[VW-1]) begin
            x0_in = y_in;
            y0_in = -x_in;
            z0_in = ANG_HALF_PI;
         end else begin
            x0_in = -y_in;
            y0_in = x_in;
            z0_in = -ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vx_ff[0]   <= x0_in;
         vy_ff[0]   <= y0_in;
         vz_ff[0]   <= z0_in;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      logic signed [VW-1:0] dx, dy;
      logic signed [ZW-1:0] at;
      assign dx = vy_ff[i] >>> i;
      assign dy = vx_ff[i] >>> i;
      assign at = atan_entry(i);
      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!vy_ff[i][VW-1]) begin
               vx_ff[i+1] <= vx_ff[i] + dx;
               vy_ff[i+1] <= vy_ff[i] - dy;
               vz_ff[i+1] <= vz_ff[i] + at;
            end else begin
               vx_ff[i+1] <= vx_ff[i] - dx;
               vy_ff[i+1] <= vy_ff[i] + dy;
               vz_ff[i+1] <= vz_ff[i] - at;
            end
         end
      end
   end

   assign zr = vz_ff[CORDIC_STAGES] + 32'sd16384;

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= zero_ff[CORDIC_STAGES] ? '0 : AW'(zr >>> 15);
      end
   end

   assign angle = angle_ff;

endmodule

// ----- rtl/core/drive_alignment_torque_top.sv -----
// Top level of the drive alignment torque block: rotation CORDIC, products,
// two vectoring CORDICs, weighting and saturation. Depends on dat_pkg,
// dat_if and dat_vec_cordic.
//
//  channel | direction | transaction
//  req_if  | in        | pivot_angle, pos_x, pos_y, weight_ang, weight_lin, last_drive
//  rsp_if  | out       | align_torque, last_result
//  csr_if  | in        | index, data (0 force_x, 1 force_y, 2 force_rot)
//
// One transaction per cycle while req_if.ready is high; each passes through the
// CORDIC pipelines, the multiply stages and the output register.
// A write to force_x or force_y starts the force length square root, which
// runs on its own unit and holds req_if.ready low meanwhile.
// Reset clears the force registers and all valid bits.
// The pipeline advances while its last stage is empty or the output register is empty or drains.
module drive_alignment_torque_top import dat_pkg::*; (
   input  logic clock,
   input  logic reset,
   dat_req_if.sink   req_if,
   dat_rsp_if.source rsp_if,
   dat_csr_if.sink   csr_if
);

   typedef enum logic [1:0] {SQ_IDLE, SQ_SQUARE, SQ_ROOT} sq_state_type;

   sq_state_type sq_state_ff;
   logic [SQW-1:0] rem_ff, root_ff, bit_ff;
   logic [LW-1:0]  len_ff;
   logic [SQW-1:0] trial, root_next;
   logic signed [2*FW-1:0] fxx, fyy;
   logic [2*FW-1:0] sq_sum;

   logic signed [FW-1:0] force_x_ff, force_y_ff, force_rot_ff;
   logic csr_take, sq_start;

   logic pipe_en, req_take, out_load;
   logic [PIPE_DEPTH-1:0] vld_ff;
   tag_type tag_ff [0:PIPE_DEPTH-1];

   logic signed [RW-1:0] rx_ff [0:CORDIC_STAGES];
   logic signed [RW-1:0] ry_ff [0:CORDIC_STAGES];
   logic signed [ZW-1:0] rz_ff [0:CORDIC_STAGES];
   pos_type pos_ff [0:CORDIC_STAGES];
   logic signed [ZW-1:0] zq, z0_in;
   logic neg0_in;

   logic signed [VW-1:0] m_xpx_ff, m_ypy_ff, m_ypx_ff, m_xpy_ff;
   logic signed [VW-1:0] m_xfy_ff, m_yfx_ff, m_xfx_ff, m_yfy_ff;
   logic mp_neg_ff;
   logic signed [VW-1:0] sa_y, sa_x, sl_y, sl_x;
   logic signed [VW-1:0] va_y_ff, va_x_ff, vl_y_ff, vl_x_ff;
   logic signed [AW-1:0] ang, lin;

   logic signed [2*FW:0]   p0_ff;
   logic signed [FW+LW:0]  p1_ff;
   logic signed [AW-1:0]   ang_m1_ff, lin_m1_ff;
   logic signed [2*FW+AW:0]  t0_ff;
   logic signed [FW+LW+AW:0] t1_ff;
   logic signed [55:0] sum_ff;
   logic signed [34:0] res;
   logic signed [OW-1:0] torque_in;

   logic out_vld_ff;
   logic signed [OW-1:0] out_torque_ff;
   logic out_last_ff;

   // configuration
   assign csr_if.ready = 1'b1;
   assign csr_take = csr_if.valid && csr_if.ready;
   assign sq_start = csr_take &&
                     (csr_if.index == CSR_FORCE_X || csr_if.index == CSR_FORCE_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         force_x_ff   <= '0;
         force_y_ff   <= '0;
         force_rot_ff <= '0;
      end else if (csr_take) begin
         case (csr_if.index)
            CSR_FORCE_X:   force_x_ff   <= csr_if.data;
            CSR_FORCE_Y:   force_y_ff   <= csr_if.data;
            CSR_FORCE_ROT: force_rot_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // force length square root, one result bit per cycle
   assign fxx = force_x_ff * force_x_ff;
   assign fyy = force_y_ff * force_y_ff;
   assign sq_sum = unsigned'(fxx) + unsigned'(fyy);
   assign trial = root_ff + bit_ff;
   assign root_next = (rem_ff >= trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_state_ff <= SQ_IDLE;
         len_ff      <= '0;
      end else if (sq_start) begin
         sq_state_ff <= SQ_SQUARE;
      end else begin
         case (sq_state_ff)
            SQ_IDLE: ;
            SQ_SQUARE: begin
               rem_ff      <= SQW'(sq_sum) << 8;
               root_ff     <= '0;
               bit_ff      <= SQW'(1) << (SQW - 2);
               sq_state_ff <= SQ_ROOT;
            end
            SQ_ROOT: begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
               end
               root_ff <= root_next;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  len_ff      <= root_next[LW-1:0];
                  sq_state_ff <= SQ_IDLE;
               end
            end
            default: sq_state_ff <= SQ_IDLE;
         endcase
      end
   end

   // pipeline control
   assign pipe_en  = !vld_ff[LAST_STAGE] || !out_vld_ff || rsp_if.ready;
   assign out_load = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = pipe_en && (sq_state_ff == SQ_IDLE);
   assign req_take = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_take};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tag_ff[0] <= '{weight_ang: req_if.weight_ang, weight_lin: req_if.weight_lin,
                        last: req_if.last_drive};
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // rotation CORDIC with reduction into +-pi/2
   assign zq = ZW'(req_if.pivot_angle) <<< 15;

   always_comb begin
      z0_in   = zq;
      neg0_in = 1'b0;
      if (zq > ANG_HALF_PI) begin
         z0_in   = zq - ANG_PI;
         neg0_in = 1'b1;
      end else if (zq < -ANG_HALF_PI) begin
         z0_in   = zq + ANG_PI;
         neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rx_ff[0]  <= ONE_Q28;
         ry_ff[0]  <= '0;
         rz_ff[0]  <= z0_in;
         pos_ff[0] <= '{px: req_if.pos_x, py: req_if.pos_y, neg: neg0_in};
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [RW-1:0] dx, dy;
      logic signed [ZW-1:0] at;
      assign dx = ry_ff[i] >>> i;
      assign dy = rx_ff[i] >>> i;
      assign at = atan_entry(i);
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            pos_ff[i+1] <= pos_ff[i];
            if (!rz_ff[i][ZW-1]) begin
               rx_ff[i+1] <= rx_ff[i] - dx;
               ry_ff[i+1] <= ry_ff[i] + dy;
               rz_ff[i+1] <= rz_ff[i] - at;
            end else begin
               rx_ff[i+1] <= rx_ff[i] + dx;
               ry_ff[i+1] <= ry_ff[i] - dy;
               rz_ff[i+1] <= rz_ff[i] + at;
            end
         end
      end
   end

   // products of c, s with position and force
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m_xpx_ff  <= rx_ff[CORDIC_STAGES] * pos_ff[CORDIC_STAGES].px;
         m_ypy_ff  <= ry_ff[CORDIC_STAGES] * pos_ff[CORDIC_STAGES].py;
         m_ypx_ff  <= ry_ff[CORDIC_STAGES] * pos_ff[CORDIC_STAGES].px;
         m_xpy_ff  <= rx_ff[CORDIC_STAGES] * pos_ff[CORDIC_STAGES].py;
         m_xfy_ff  <= rx_ff[CORDIC_STAGES] * force_y_ff;
         m_yfx_ff  <= ry_ff[CORDIC_STAGES] * force_x_ff;
         m_xfx_ff  <= rx_ff[CORDIC_STAGES] * force_x_ff;
         m_yfy_ff  <= ry_ff[CORDIC_STAGES] * force_y_ff;
         mp_neg_ff <= pos_ff[CORDIC_STAGES].neg;
      end
   end

   assign sa_y = m_xpx_ff + m_ypy_ff;
   assign sa_x = m_ypx_ff - m_xpy_ff;
   assign sl_y = m_xfy_ff - m_yfx_ff;
   assign sl_x = m_xfx_ff + m_yfy_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         va_y_ff <= mp_neg_ff ? -sa_y : sa_y;
         va_x_ff <= mp_neg_ff ? -sa_x : sa_x;
         vl_y_ff <= mp_neg_ff ? -sl_y : sl_y;
         vl_x_ff <= mp_neg_ff ? -sl_x : sl_x;
      end
   end

   dat_vec_cordic u_vec_ang (
      .clock  (clock),
      .enable (pipe_en),
      .y_in   (va_y_ff),
      .x_in   (va_x_ff),
      .angle  (ang)
   );

   dat_vec_cordic u_vec_lin (
      .clock  (clock),
      .enable (pipe_en),
      .y_in   (vl_y_ff),
      .x_in   (vl_x_ff),
      .angle  (lin)
   );

   // weighting, rounding, saturation
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p0_ff     <= signed'({1'b0, tag_ff[M1_STAGE-1].weight_ang}) * force_rot_ff;
         p1_ff     <= signed'({1'b0, (FW+LW)'(tag_ff[M1_STAGE-1].weight_lin) *
                                     (FW+LW)'(len_ff)});
         ang_m1_ff <= ang;
         lin_m1_ff <= lin;
         t0_ff     <= p0_ff * ang_m1_ff;
         t1_ff     <= p1_ff * lin_m1_ff;
         sum_ff    <= (56'(t0_ff) <<< 4) + 56'(t1_ff) + 56'sd1048576;
      end
   end

   assign res = 35'(sum_ff >>> 21);

   always_comb begin
      if (res > 35'sd2147483647) begin
         torque_in = 32'sh7FFFFFFF;
      end else if (res < -35'sd2147483648) begin
         torque_in = 32'sh80000000;
      end else begin
         torque_in = res[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= vld_ff[LAST_STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && vld_ff[LAST_STAGE]) begin
         out_torque_ff <= torque_in;
         out_last_ff   <= tag_ff[LAST_STAGE].last;
      end
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.align_torque = out_torque_ff;
   assign rsp_if.last_result  = out_last_ff;

   a_no_take_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      req_take |-> sq_state_ff == SQ_IDLE)
      else $error("transaction accepted during force length update");

   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      pipe_en |=> vld_ff[1] == $past(vld_ff[0]))
      else $error("valid bit lost in pipeline");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_if.ready && vld_ff[LAST_STAGE]) |-> !pipe_en)
      else $error("pipeline advanced into a full output register");

   a_rise_src: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(vld_ff[LAST_STAGE]))
      else $error("result without a transaction in the last stage");

endmodule
